[hdl/tfl_pkg.sv]
// tfl_pkg: shared types and constants of the TCP flow tracker.
// No dependencies; used by the interfaces, controller, datapath and top level.
package tfl_pkg;

    localparam int unsigned HDR_MIN    = 20;
    localparam int unsigned WORD_BYTES = 4;
    localparam int unsigned NUM_SLOTS  = 5;

    // result slot order within one segment
    localparam int unsigned SLOT_DATA    = 0;
    localparam int unsigned SLOT_REL_SRV = 1;
    localparam int unsigned SLOT_REL_CLI = 2;
    localparam int unsigned SLOT_CLOSE   = 3;
    localparam int unsigned SLOT_VERDICT = 4;

    localparam logic [1:0] EV_VERDICT = 2'd0;
    localparam logic [1:0] EV_DATA    = 2'd1;
    localparam logic [1:0] EV_CLOSED  = 2'd2;

    localparam logic [1:0] FS_SYN_SENT   = 2'd0;
    localparam logic [1:0] FS_SYNACK     = 2'd1;
    localparam logic [1:0] FS_ESTABLISHED = 2'd2;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic        syn_flag;
        logic        ack_flag;
        logic        fin_flag;
        logic        rst_flag;
        logic [3:0]  data_offset;
        logic [15:0] segment_len;
    } t_segment;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic        from_client;
        logic [14:0] flush_len;
        logic [3:0]  flow_index;
        logic        verdict_ok;
        logic        last;
    } t_event;

    typedef struct packed {
        logic idle;
        logic look;
        logic decide;
        logic emit;
    } t_ctl_cmd;

    typedef struct packed {
        logic pop_fire;
        logic pop_last;
    } t_ctl_sts;

endpackage

[hdl/tfl_seg_if.sv]
// tfl_seg_if / tfl_evt_if: valid/ready channels for segments and events.
// Depends on tfl_pkg.
interface tfl_seg_if;
    logic              valid;
    logic              ready;
    tfl_pkg::t_segment payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tfl_evt_if;
    logic            valid;
    logic            ready;
    tfl_pkg::t_event payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/tfl_ctrl.sv]
// tfl_ctrl: sequencer of the flow tracker (idle, look up, decide, emit).
// Depends on tfl_pkg.
module tfl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_seg_valid,
    input  tfl_pkg::t_ctl_sts i_sts,
    output tfl_pkg::t_ctl_cmd o_cmd
);
    typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_DECIDE, ST_EMIT} t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_seg_valid) n_state = ST_LOOK;
            ST_LOOK:   n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_EMIT;
            ST_EMIT:   if (i_sts.pop_fire && i_sts.pop_last) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.idle   = (r_state == ST_IDLE);
    assign o_cmd.look   = (r_state == ST_LOOK);
    assign o_cmd.decide = (r_state == ST_DECIDE);
    assign o_cmd.emit   = (r_state == ST_EMIT);

    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.pop_fire && i_sts.pop_last) |=> o_cmd.idle)
        else $error("emit did not return to idle");
    a_decide_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.decide |=> o_cmd.emit)
        else $error("decide not followed by emit");
    a_look_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.look |-> $past(o_cmd.idle && i_seg_valid))
        else $error("lookup without accepted segment");
endmodule

[hdl/tfl_datapath.sv]
// tfl_datapath: flow table, segment register, decision logic, result slots
// and output register. Depends on tfl_pkg; driven by tfl_ctrl.
module tfl_datapath #(
    parameter int unsigned TABLE_ENTRIES = 16,
    parameter int unsigned BUFFER_BYTES  = 16384
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tfl_pkg::t_ctl_cmd i_cmd,
    output tfl_pkg::t_ctl_sts o_sts,
    input  logic              i_seg_valid,
    input  tfl_pkg::t_segment i_seg,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    output logic              o_evt_valid,
    input  logic              i_evt_ready,
    output tfl_pkg::t_event   o_evt
);
    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned BW = $clog2(BUFFER_BYTES + 1);

    logic                  r_accept_new;
    tfl_pkg::t_segment     r_in;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [TABLE_ENTRIES-1:0] r_hit_fwd;
    logic [TABLE_ENTRIES-1:0] r_hit_rev;
    logic [31:0] r_cip [TABLE_ENTRIES];
    logic [31:0] r_sip [TABLE_ENTRIES];
    logic [15:0] r_cpt [TABLE_ENTRIES];
    logic [15:0] r_spt [TABLE_ENTRIES];
    logic [1:0]  r_fst [TABLE_ENTRIES];
    logic [31:0] r_cseq [TABLE_ENTRIES];
    logic [31:0] r_sseq [TABLE_ENTRIES];
    logic [BW-1:0] r_cbuf [TABLE_ENTRIES];
    logic [BW-1:0] r_sbuf [TABLE_ENTRIES];

    tfl_pkg::t_event r_slot [tfl_pkg::NUM_SLOTS];
    logic [tfl_pkg::NUM_SLOTS-1:0] r_slot_v;
    tfl_pkg::t_event r_out;
    logic            r_out_v;

    // decision results
    tfl_pkg::t_event n_slot [tfl_pkg::NUM_SLOTS];
    logic [tfl_pkg::NUM_SLOTS-1:0] n_slot_v;
    logic          wr_en, set_valid, clr_valid;
    logic [IW-1:0] idx;
    logic [1:0]    n_fst;
    logic [31:0]   n_cip, n_sip, n_cseq, n_sseq;
    logic [15:0]   n_cpt, n_spt;
    logic [BW-1:0] n_cbuf, n_sbuf;

    function automatic logic [3:0] idx4(input logic [IW-1:0] v);
        logic [IW+3:0] x;
        x = {4'b0, v};
        return x[3:0];
    endfunction

    function automatic logic [14:0] len15(input logic [BW-1:0] v);
        logic [BW+14:0] x;
        x = {15'b0, v};
        return x[14:0];
    endfunction

    function automatic tfl_pkg::t_event mk(input logic [1:0] kind, input logic fc,
                                           input logic [14:0] len, input logic [3:0] fi,
                                           input logic ok, input logic lst);
        tfl_pkg::t_event e;
        e.event_kind  = kind;
        e.from_client = fc;
        e.flush_len   = len;
        e.flow_index  = fi;
        e.verdict_ok  = ok;
        e.last        = lst;
        return e;
    endfunction

    always_comb begin
        logic [5:0]  hdr;
        logic [15:0] pay;
        logic        bad, found, fc, free_ok, ok, do_close;
        logic [IW-1:0] free_idx;
        logic [BW-1:0] own_buf, oth_buf;
        logic [31:0] own_seq, oth_sum;
        logic [16:0] grow;
        hdr = {r_in.data_offset, 2'b00};
        pay = r_in.segment_len - {10'b0, hdr};
        bad = (r_in.segment_len < 16'(tfl_pkg::HDR_MIN)) || ({10'b0, hdr} > r_in.segment_len);
        found = 1'b0; fc = 1'b0; idx = '0; free_ok = 1'b0; free_idx = '0;
        // priority to the lowest entry: scan downward, last hit wins
        for (int e = TABLE_ENTRIES - 1; e >= 0; e--) begin
            if (r_hit_fwd[e] || r_hit_rev[e]) begin
                found = 1'b1; idx = IW'(e); fc = r_hit_fwd[e];
            end
            if (!r_valid[e]) begin
                free_ok = 1'b1; free_idx = IW'(e);
            end
        end
        n_cip = r_cip[idx]; n_sip = r_sip[idx]; n_cpt = r_cpt[idx]; n_spt = r_spt[idx];
        n_fst = r_fst[idx]; n_cseq = r_cseq[idx]; n_sseq = r_sseq[idx];
        n_cbuf = r_cbuf[idx]; n_sbuf = r_sbuf[idx];
        wr_en = 1'b0; set_valid = 1'b0; clr_valid = 1'b0;
        ok = 1'b0; do_close = 1'b0;
        own_buf = '0; oth_buf = '0; own_seq = '0; oth_sum = '0; grow = '0;
        for (int s = 0; s < tfl_pkg::NUM_SLOTS; s++) n_slot[s] = '0;
        n_slot_v = '0;
        n_slot_v[tfl_pkg::SLOT_VERDICT] = 1'b1;

        if (bad) begin
            n_slot[tfl_pkg::SLOT_VERDICT] = mk(tfl_pkg::EV_VERDICT, 1'b0, '0, '0, 1'b0, 1'b1);
        end else if (r_in.syn_flag && !r_in.ack_flag) begin
            if (!found && free_ok) begin
                found = 1'b1; idx = free_idx;
            end
            if (!found) begin
                n_slot[tfl_pkg::SLOT_VERDICT] =
                    mk(tfl_pkg::EV_VERDICT, 1'b0, '0, '0, 1'b0, 1'b1);
            end else begin
                wr_en = 1'b1; set_valid = 1'b1;
                n_cip = r_in.src_ip; n_cpt = r_in.src_port;
                n_sip = r_in.dst_ip; n_spt = r_in.dst_port;
                n_fst = tfl_pkg::FS_SYN_SENT; n_cseq = r_in.seq_num; n_sseq = '0;
                n_cbuf = '0; n_sbuf = '0;
                n_slot[tfl_pkg::SLOT_VERDICT] =
                    mk(tfl_pkg::EV_VERDICT, 1'b1, '0, idx4(idx), 1'b1, 1'b1);
            end
        end else if (!found) begin
            n_slot[tfl_pkg::SLOT_VERDICT] = mk(tfl_pkg::EV_VERDICT, 1'b0, '0, '0, 1'b1, 1'b1);
        end else begin
            wr_en = 1'b1;
            if (r_in.ack_flag) begin
                case (n_fst)
                    tfl_pkg::FS_SYN_SENT: begin
                        if (!fc && r_in.syn_flag && (n_cseq + 32'd1 == r_in.ack_num)) begin
                            n_cseq = r_in.ack_num; n_sseq = r_in.seq_num;
                            n_fst = tfl_pkg::FS_SYNACK; ok = 1'b1;
                        end
                    end
                    tfl_pkg::FS_SYNACK: begin
                        if (fc && (n_sseq + 32'd1 == r_in.ack_num) && r_accept_new) begin
                            n_sseq = r_in.ack_num;
                            n_fst = tfl_pkg::FS_ESTABLISHED; ok = 1'b1;
                        end
                    end
                    tfl_pkg::FS_ESTABLISHED: begin
                        ok = 1'b1;
                        own_buf = fc ? n_cbuf : n_sbuf;
                        own_seq = fc ? n_cseq : n_sseq;
                        if (own_seq + 32'(own_buf) == r_in.seq_num) begin
                            grow = 17'(own_buf) + {1'b0, pay};
                            if (grow > 17'(BUFFER_BYTES)) begin
                                ok = 1'b0;
                            end else if (fc) begin
                                n_cbuf = BW'(grow);
                            end else begin
                                n_sbuf = BW'(grow);
                            end
                        end
                        if (ok) begin
                            oth_buf = fc ? n_sbuf : n_cbuf;
                            oth_sum = (fc ? n_sseq : n_cseq) + 32'(oth_buf);
                            if (oth_sum == r_in.ack_num && oth_buf != '0) begin
                                // release the opposite direction
                                n_slot_v[tfl_pkg::SLOT_DATA] = 1'b1;
                                n_slot[tfl_pkg::SLOT_DATA] = mk(tfl_pkg::EV_DATA, !fc,
                                    len15(oth_buf), idx4(idx), 1'b0, 1'b0);
                                if (fc) begin
                                    n_sseq = oth_sum; n_sbuf = '0;
                                end else begin
                                    n_cseq = oth_sum; n_cbuf = '0;
                                end
                            end
                        end
                    end
                    default: ok = 1'b0;
                endcase
            end
            do_close = !ok || r_in.fin_flag || r_in.rst_flag;
            if (do_close) begin
                clr_valid = 1'b1;
                if (n_fst == tfl_pkg::FS_ESTABLISHED) begin
                    n_slot_v[tfl_pkg::SLOT_REL_SRV] = (n_sbuf != '0);
                    n_slot[tfl_pkg::SLOT_REL_SRV] = mk(tfl_pkg::EV_DATA, 1'b0,
                        len15(n_sbuf), idx4(idx), 1'b0, 1'b0);
                    n_slot_v[tfl_pkg::SLOT_REL_CLI] = (n_cbuf != '0);
                    n_slot[tfl_pkg::SLOT_REL_CLI] = mk(tfl_pkg::EV_DATA, 1'b1,
                        len15(n_cbuf), idx4(idx), 1'b0, 1'b0);
                    n_slot_v[tfl_pkg::SLOT_CLOSE] = 1'b1;
                    n_slot[tfl_pkg::SLOT_CLOSE] = mk(tfl_pkg::EV_CLOSED, 1'b0, '0,
                        idx4(idx), 1'b0, 1'b0);
                end
            end
            n_slot[tfl_pkg::SLOT_VERDICT] =
                mk(tfl_pkg::EV_VERDICT, fc, '0, idx4(idx), ok, 1'b1);
        end
    end

    // pick the first pending slot
    tfl_pkg::t_event pop_evt;
    logic [tfl_pkg::NUM_SLOTS-1:0] pop_mask;
    always_comb begin
        pop_evt  = r_slot[tfl_pkg::SLOT_VERDICT];
        pop_mask = '0;
        for (int s = tfl_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
            if (r_slot_v[s]) begin
                pop_evt  = r_slot[s];
                pop_mask = '0;
                pop_mask[s] = 1'b1;
            end
        end
    end

    assign o_sts.pop_fire = i_cmd.emit && (|r_slot_v) && (!r_out_v || i_evt_ready);
    assign o_sts.pop_last = ((r_slot_v & ~pop_mask) == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_new <= 1'b1;
            r_valid      <= '0;
            r_slot_v     <= '0;
            r_out_v      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_accept_new <= i_cfg_wr_data;
            if (i_cmd.decide) begin
                r_slot_v <= n_slot_v;
                if (set_valid) r_valid[idx] <= 1'b1;
                else if (clr_valid) r_valid[idx] <= 1'b0;
            end else if (o_sts.pop_fire) begin
                r_slot_v <= r_slot_v & ~pop_mask;
            end
            if (o_sts.pop_fire) r_out_v <= 1'b1;
            else if (i_evt_ready) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idle && i_seg_valid) r_in <= i_seg;
        if (i_cmd.look) begin
            for (int e = 0; e < TABLE_ENTRIES; e++) begin
                r_hit_fwd[e] <= r_valid[e] && r_cip[e] == r_in.src_ip &&
                    r_cpt[e] == r_in.src_port && r_sip[e] == r_in.dst_ip &&
                    r_spt[e] == r_in.dst_port;
                r_hit_rev[e] <= r_valid[e] && r_cip[e] == r_in.dst_ip &&
                    r_cpt[e] == r_in.dst_port && r_sip[e] == r_in.src_ip &&
                    r_spt[e] == r_in.src_port;
            end
        end
        if (i_cmd.decide) begin
            for (int s = 0; s < tfl_pkg::NUM_SLOTS; s++) r_slot[s] <= n_slot[s];
            if (wr_en) begin
                r_cip[idx] <= n_cip; r_sip[idx] <= n_sip;
                r_cpt[idx] <= n_cpt; r_spt[idx] <= n_spt;
                r_fst[idx] <= n_fst; r_cseq[idx] <= n_cseq; r_sseq[idx] <= n_sseq;
                r_cbuf[idx] <= n_cbuf; r_sbuf[idx] <= n_sbuf;
            end
        end
        if (o_sts.pop_fire) r_out <= pop_evt;
    end

    assign o_evt_valid = r_out_v;
    assign o_evt       = r_out;

    a_verdict_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide |=> r_slot_v[tfl_pkg::SLOT_VERDICT])
        else $error("verdict slot missing after decision");
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.idle |-> (r_slot_v == '0))
        else $error("results pending while idle");
    a_last_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sts.pop_fire && o_sts.pop_last) |-> pop_evt.last)
        else $error("final result without last flag");
endmodule

[hdl/tcp_flow_tracker.sv]
// tcp_flow_tracker: top level; joins the sequencer and the datapath.
// Depends on tfl_pkg, tfl_seg_if/tfl_evt_if, tfl_ctrl, tfl_datapath.
//
// Tracks TCP connections in a table of TABLE_ENTRIES flows held in registers.
// One segment is taken per transfer on i_seg and answered by one to four
// events on o_evt, the verdict always last (last = 1); data events and a
// close event come before it. A segment passes through these steps in order:
// the segment is registered, the 4-tuple is compared against all entries at
// once, the decision is made and the entry written back, then each event goes
// through the output register. A low o_evt.ready stalls the emit step while an
// event waits in the output register. The next segment is taken once the last
// event of the current one has moved into the output register. accept_new
// resets to 1 and is written through i_cfg_wr_en/i_cfg_wr_data; the user must
// keep such writes to idle time, as the block has no check for it. The table
// needs no clearing pass after reset.
module tcp_flow_tracker #(
    parameter int unsigned TABLE_ENTRIES = 16,
    parameter int unsigned BUFFER_BYTES  = 16384
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tfl_seg_if.sink   i_seg,
    tfl_evt_if.source o_evt,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data
);
    tfl_pkg::t_ctl_cmd cmd;
    tfl_pkg::t_ctl_sts sts;

    // accept a segment only when the sequencer is idle
    assign i_seg.ready = cmd.idle;

    tfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg_valid (i_seg.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tfl_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .BUFFER_BYTES  (BUFFER_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_seg_valid   (i_seg.valid),
        .i_seg         (i_seg.payload),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_evt_valid   (o_evt.valid),
        .i_evt_ready   (o_evt.ready),
        .o_evt         (o_evt.payload)
    );
endmodule
